>>> src/prx_pkg.sv
// ----------------------------------------------------------------------------
// prx_pkg
// Shared types, constants and helpers for the printable run extractor.
// ----------------------------------------------------------------------------
package prx_pkg;

  localparam int BYTE_W     = 8;
  localparam int OFFSET_W   = 32;
  localparam int LEN_W      = 6;
  localparam int MAX_LENGTH_DEF = 32;

  // run counter stops here
  localparam logic [LEN_W-1:0] RUN_SAT        = 6'd63;
  localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 6'd4;

  localparam logic [BYTE_W-1:0] CHR_TAB      = 8'h09;
  localparam logic [BYTE_W-1:0] CHR_PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] CHR_PRINT_HI = 8'h7E;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BURST_RD,
    ST_BURST_WR
  } prx_state_t;

  // printable ASCII or tab
  function automatic logic is_printable(input logic [BYTE_W-1:0] b);
    return ((b >= CHR_PRINT_LO) && (b <= CHR_PRINT_HI)) || (b == CHR_TAB);
  endfunction

endpackage

>>> src/prx_if.sv
// ----------------------------------------------------------------------------
// prx_if
// Valid/ready channel interfaces: byte input, result output, config write.
// ----------------------------------------------------------------------------
interface prx_in_if;
  import prx_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface prx_out_if;
  import prx_pkg::*;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                is_terminator;
  logic [OFFSET_W-1:0] start_offset;
  logic                last;

  modport source (output valid, output out_byte, output is_terminator,
                  output start_offset, output last, input ready);
  modport sink   (input valid, input out_byte, input is_terminator,
                  input start_offset, input last, output ready);
endinterface

interface prx_cfg_if;
  import prx_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] min_length;

  modport source (output valid, output min_length, input ready);
  modport sink   (input valid, input min_length, output ready);
endinterface

>>> src/prx_run_mem.sv
// ----------------------------------------------------------------------------
// prx_run_mem
// Run buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module prx_run_mem #(
  parameter int DEPTH = prx_pkg::MAX_LENGTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [prx_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [prx_pkg::BYTE_W-1:0] rd_data
);
  import prx_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/prx_ctrl.sv
// ----------------------------------------------------------------------------
// prx_ctrl
// Run tracking, burst sequencer over the run buffer, output register.
// ----------------------------------------------------------------------------
module prx_ctrl #(
  parameter int MAX_LENGTH = prx_pkg::MAX_LENGTH_DEF,
  localparam int AW        = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  prx_in_if.sink                     in_chan,
  prx_out_if.source                  out_chan,
  input  logic [prx_pkg::LEN_W-1:0]  min_eff,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [prx_pkg::BYTE_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [prx_pkg::BYTE_W-1:0] mem_rdata
);
  import prx_pkg::*;

  prx_state_t          state_r, state_nxt;
  logic [LEN_W-1:0]    run_len_r, run_len_nxt;
  logic [OFFSET_W-1:0] byte_off_r, byte_off_nxt;
  logic [OFFSET_W-1:0] run_start_r, run_start_nxt;
  logic [AW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]       last_idx_r, last_idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_term_r, out_term_nxt;
  logic [OFFSET_W-1:0] out_off_r, out_off_nxt;
  logic                out_last_r, out_last_nxt;

  logic out_free;
  logic accept;
  logic prn;
  logic burst_start;
  logic burst_load;
  logic burst_done;

  // output register can take a new result this cycle
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE) && out_free;
  assign accept = in_chan.valid && in_chan.ready;
  assign prn = !in_chan.end_of_file && is_printable(in_chan.data_byte);

  // burst begins when the held run reaches the minimum
  assign burst_start = accept && prn && (run_len_r < min_eff)
                       && (({1'b0, run_len_r} + 7'd1) == {1'b0, min_eff});
  assign burst_load  = (state_r == ST_BURST_WR) && out_free;
  assign burst_done  = burst_load && (rd_idx_r == last_idx_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (burst_start) begin
          state_nxt = ST_BURST_RD;
        end
      end
      ST_BURST_RD: begin
        state_nxt = ST_BURST_WR;
      end
      ST_BURST_WR: begin
        if (burst_done) begin
          state_nxt = ST_IDLE;
        end else if (burst_load) begin
          state_nxt = ST_BURST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // run state, buffer access and result datapath
  always_comb begin
    run_len_nxt   = run_len_r;
    byte_off_nxt  = byte_off_r;
    run_start_nxt = run_start_r;
    rd_idx_nxt    = rd_idx_r;
    last_idx_nxt  = last_idx_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_byte_nxt  = out_byte_r;
    out_term_nxt  = out_term_r;
    out_off_nxt   = out_off_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = run_len_r[AW-1:0];
    mem_wdata     = in_chan.data_byte;
    mem_re        = (state_r == ST_BURST_RD);
    mem_raddr     = rd_idx_r;

    if (accept) begin
      if (!prn) begin
        // terminator only for a run that was reported
        if (run_len_r >= min_eff) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = '0;
          out_term_nxt  = 1'b1;
          out_off_nxt   = run_start_r;
          out_last_nxt  = 1'b1;
        end
        run_len_nxt  = '0;
        byte_off_nxt = in_chan.end_of_file ? '0 : byte_off_r + 32'd1;
      end else begin
        if (run_len_r == '0) begin
          run_start_nxt = byte_off_r;
        end
        if (run_len_r < min_eff) begin
          mem_we = 1'b1;
          if (burst_start) begin
            rd_idx_nxt   = '0;
            last_idx_nxt = AW'(min_eff - 6'd1);
          end
        end else begin
          // pass-through byte of a reported run
          out_valid_nxt = 1'b1;
          out_byte_nxt  = in_chan.data_byte;
          out_term_nxt  = 1'b0;
          out_off_nxt   = (run_len_r == '0) ? byte_off_r : run_start_r;
          out_last_nxt  = 1'b1;
        end
        if (run_len_r != RUN_SAT) begin
          run_len_nxt = run_len_r + 6'd1;
        end
        byte_off_nxt = byte_off_r + 32'd1;
      end
    end

    // burst: one held byte per read/load pair
    if (burst_load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = mem_rdata;
      out_term_nxt  = 1'b0;
      out_off_nxt   = run_start_r;
      out_last_nxt  = burst_done;
      rd_idx_nxt    = rd_idx_r + AW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_len_r   <= '0;
      byte_off_r  <= '0;
      run_start_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_len_r   <= run_len_nxt;
      byte_off_r  <= byte_off_nxt;
      run_start_r <= run_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    last_idx_r <= last_idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_term_r <= out_term_nxt;
    out_off_r  <= out_off_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_byte      = out_byte_r;
  assign out_chan.is_terminator = out_term_r;
  assign out_chan.start_offset  = out_off_r;
  assign out_chan.last          = out_last_r;

endmodule

>>> src/printable_run_extractor_top.sv
// ----------------------------------------------------------------------------
// printable_run_extractor_top
// Reports runs of printable bytes with their start offsets.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one request per stream byte, or an end-of-file mark.
//   out_chan : result requests; a reported string is a burst of its first
//              min_length bytes, then one result per further byte, then a
//              terminator. last marks the final result of one input request.
//   cfg_chan : writes min_length; always ready, write only while idle.
// Output: a single result is registered in the output register when its
//   input request is taken.
// Throughput: one input request per cycle while bytes pass through and the
//   output register is free. The request that completes a minimum-length run
//   starts a burst read of the run buffer, one read plus one output load per
//   byte, during which in_chan is not ready.
// Reset: rst_n low clears the run counter, the offsets, the burst sequencer
//   and the output valid; min_length returns to 4. The buffer is not cleared.
// Stall: a held result waits in the output register; input is not taken
//   until that result is delivered or leaves in the same cycle.
// ----------------------------------------------------------------------------
module printable_run_extractor_top #(
  parameter int MAX_LENGTH = prx_pkg::MAX_LENGTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  prx_in_if.sink    in_chan,
  prx_out_if.source out_chan,
  prx_cfg_if.sink   cfg_chan
);
  import prx_pkg::*;

  localparam int AW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LIMIT = (MAX_LENGTH > 63) ? 63 : MAX_LENGTH;

  logic [LEN_W-1:0]  min_length_r;
  logic [LEN_W-1:0]  min_lo;
  logic [LEN_W-1:0]  min_eff;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // configuration register
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= MIN_LENGTH_RST;
    end else if (cfg_chan.valid) begin
      min_length_r <= cfg_chan.min_length;
    end
  end

  // effective minimum: zero acts as one, clipped to the buffer depth and to 63
  assign min_lo  = (min_length_r == '0) ? 6'd1 : min_length_r;
  assign min_eff = ({1'b0, min_lo} > 7'(LIMIT)) ? 6'(LIMIT) : min_lo;

  prx_run_mem #(
    .DEPTH (MAX_LENGTH)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rd_data (mem_rdata)
  );

  prx_ctrl #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .min_eff   (min_eff),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

>>> src/prx_checker.sv
// ----------------------------------------------------------------------------
// prx_checker
// Port-level checks on the printable run extractor, bound to the top level.
// ----------------------------------------------------------------------------
module prx_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [prx_pkg::BYTE_W-1:0]  out_byte,
  input logic                        is_terminator,
  input logic                        last
);
  import prx_pkg::*;

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // no new input while the output register is blocked
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("input taken while output register is full");

  // terminators carry a zero byte and close their request's results
  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_terminator |-> (out_byte == '0) && last)
    else $error("malformed terminator");

  // reset empties the output register
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input is never accepted while a mid-string burst result is offered
  a_burst_lock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> !(in_valid && in_ready))
    else $error("input accepted during burst");

endmodule

bind printable_run_extractor_top prx_checker u_prx_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_byte      (out_chan.out_byte),
  .is_terminator (out_chan.is_terminator),
  .last          (out_chan.last)
);
